// ===== hdl/pact_pkg.sv =====
// Shared constants, codes and types of the priority array command table.
package pact_pkg;

   localparam int OBJECTS    = 4;
   localparam int PRIORITIES = 16;

   localparam int OBJ_AW = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;
   localparam int PRI_AW = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;

   localparam logic [7:0] EMPTY_MARK        = 8'd255;
   localparam logic [7:0] MAX_STORABLE      = 8'd254;
   localparam logic [7:0] RESERVED_PRIORITY = 8'd6;
   localparam logic [7:0] PRIORITY_COUNT    = 8'(PRIORITIES);
   localparam logic [8:0] OBJECT_COUNT      = 9'(OBJECTS);

   localparam logic [7:0] RESET_RELINQUISH_DEFAULT = 8'd0;
   localparam logic [7:0] RESET_HIGHEST_LEVEL      = 8'd254;

   typedef enum logic [1:0] {
      CMD_WRITE      = 2'd0,
      CMD_RELINQUISH = 2'd1,
      CMD_SET_OOS    = 2'd2,
      CMD_READ       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_UNKNOWN_OBJECT = 3'd1,
      ST_OUT_OF_RANGE   = 3'd2,
      ST_DENIED         = 3'd3,
      ST_BAD_INDEX      = 3'd4
   } status_type;

   typedef enum logic [7:0] {
      CSR_RELINQUISH_DEFAULT = 8'd0,
      CSR_HIGHEST_LEVEL      = 8'd1
   } csr_index_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   // One memory row per object: out-of-service bit and all slots.
   typedef struct packed {
      logic                         oos;
      logic [PRIORITIES-1:0][7:0]   slot;
   } row_type;

endpackage

// ===== hdl/priority_array_command_table.sv =====
// Top level of the priority array command table: row memory, command logic, CSRs.
//
//  channel   ports                                    handshake
//  --------  ---------------------------------------  ---------------------------
//  request   req_cmd, req_object_number, ...          start & !busy takes an item
//  response  rsp_status, rsp_present_level, ...       rsp_valid, one cycle, no stall
//  csr       csr_index, csr_wdata                     csr_valid & csr_ready
//
// On accept the object's row is read from the single-port row memory; in the
// execute state the row is modified and written back and the result registered,
// which shows on rsp_valid in the following cycle. busy is high for the one cycle
// of the read-modify-write, so a new item may be accepted in the cycle the
// previous result is shown.
// Reset clears the per-row valid bits; a row not yet written reads as all slots
// empty and out-of-service clear, so no clearing pass is needed.
module priority_array_command_table
   import pact_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_object_number,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_level_value,
   input  logic        req_oos_value,
   input  logic [7:0]  req_slot_index,
   // response
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_present_level,
   output logic        rsp_out_of_service,
   output logic [7:0]  rsp_slot_level,
   output logic        rsp_slot_empty,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   fsm_type state_ff, state_in;
   logic    accept;

   // captured item
   logic [1:0]  cmd_ff;
   logic [7:0]  object_ff;
   logic [7:0]  priority_ff;
   logic [15:0] level_ff;
   logic        oos_ff;
   logic [7:0]  slot_index_ff;

   // CSRs
   logic [7:0] relinquish_default_ff;
   logic [7:0] highest_level_ff;

   // row memory and valid bits
   row_type             row_mem [OBJECTS];
   logic [OBJECTS-1:0]  row_valid_ff;
   row_type             rd_row_ff;
   logic [OBJ_AW-1:0]   obj_idx;

   // execute stage
   row_type                 row_cur;
   row_type                 row_new;
   logic                    known;
   logic                    prio_ok;
   logic                    level_ok;
   logic [PRI_AW-1:0]       prio_sel;
   logic [PRI_AW-1:0]       read_sel;
   logic [PRIORITIES-1:0]   set_mask;
   logic [PRIORITIES-1:0]   first_set;
   logic [7:0]              present;
   logic                    wr_en;
   status_type              status_in;
   logic [7:0]              slot_level_in;
   logic                    slot_empty_in;

   // response registers
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [7:0]  rsp_present_ff;
   logic        rsp_oos_ff;
   logic [7:0]  rsp_slot_level_ff;
   logic        rsp_slot_empty_ff;

   assign busy      = (state_ff == FSM_EXEC);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // ---------------- control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // ---------------- CSRs ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         relinquish_default_ff <= RESET_RELINQUISH_DEFAULT;
         highest_level_ff      <= RESET_HIGHEST_LEVEL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RELINQUISH_DEFAULT: relinquish_default_ff <= csr_wdata;
            CSR_HIGHEST_LEVEL:      highest_level_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- item capture ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= req_cmd;
         object_ff     <= req_object_number;
         priority_ff   <= req_priority_req;
         level_ff      <= req_level_value;
         oos_ff        <= req_oos_value;
         slot_index_ff <= req_slot_index;
      end
   end

   // ---------------- row memory ----------------
   // Read on accept, write back at the end of the execute cycle; the two never
   // share an edge, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_row_ff <= row_mem[req_object_number[OBJ_AW-1:0]];
      end
      if (wr_en) begin
         row_mem[obj_idx] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[obj_idx] <= 1'b1;
      end
   end

   // ---------------- execute ----------------
   assign obj_idx  = object_ff[OBJ_AW-1:0];
   assign known    = ({1'b0, object_ff} < OBJECT_COUNT);
   assign prio_ok  = (priority_ff >= 8'd1) && (priority_ff <= PRIORITY_COUNT);
   assign level_ok = (level_ff <= {8'd0, highest_level_ff}) &&
                     (level_ff <= {8'd0, MAX_STORABLE});
   assign prio_sel = PRI_AW'(priority_ff - 8'd1);
   assign read_sel = PRI_AW'(slot_index_ff - 8'd1);
   assign wr_en    = busy && known;

   always_comb begin
      // a row never written holds all slots empty and out-of-service clear
      if (row_valid_ff[obj_idx]) begin
         row_cur = rd_row_ff;
      end else begin
         row_cur.oos  = 1'b0;
         row_cur.slot = {PRIORITIES{EMPTY_MARK}};
      end

      row_new       = row_cur;
      status_in     = ST_OK;
      slot_level_in = 8'd0;
      slot_empty_in = 1'b0;

      case (cmd_type'(cmd_ff))
         CMD_WRITE: begin
            if (prio_ok && (priority_ff != RESERVED_PRIORITY) && level_ok) begin
               row_new.slot[prio_sel] = level_ff[7:0];
            end else if (priority_ff == RESERVED_PRIORITY) begin
               status_in = ST_DENIED;
            end else begin
               status_in = ST_OUT_OF_RANGE;
            end
         end
         CMD_RELINQUISH: begin
            if (prio_ok) begin
               row_new.slot[prio_sel] = EMPTY_MARK;
            end else begin
               status_in = ST_OUT_OF_RANGE;
            end
         end
         CMD_SET_OOS: begin
            row_new.oos = oos_ff;
         end
         CMD_READ: begin
            if (slot_index_ff == 8'd0) begin
               slot_level_in = PRIORITY_COUNT;
            end else if (slot_index_ff <= PRIORITY_COUNT) begin
               if (row_cur.slot[read_sel] == EMPTY_MARK) begin
                  slot_empty_in = 1'b1;
               end else begin
                  slot_level_in = row_cur.slot[read_sel];
               end
            end else begin
               status_in = ST_BAD_INDEX;
            end
         end
         default: ;
      endcase
   end

   // Present value: lowest set slot (priority 1 first) via isolate-lowest-bit,
   // then an AND-OR select.
   always_comb begin
      for (int p = 0; p < PRIORITIES; p++) begin
         set_mask[p] = (row_new.slot[p] != EMPTY_MARK);
      end
      first_set = set_mask & (~set_mask + PRIORITIES'(1));
      present   = 8'd0;
      for (int p = 0; p < PRIORITIES; p++) begin
         present = present | (row_new.slot[p] & {8{first_set[p]}});
      end
      if (set_mask == '0) begin
         present = relinquish_default_ff;
      end
   end

   // ---------------- response ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         if (known) begin
            rsp_status_ff     <= status_in;
            rsp_present_ff    <= present;
            rsp_oos_ff        <= row_new.oos;
            rsp_slot_level_ff <= slot_level_in;
            rsp_slot_empty_ff <= slot_empty_in;
         end else begin
            rsp_status_ff     <= ST_UNKNOWN_OBJECT;
            rsp_present_ff    <= 8'd0;
            rsp_oos_ff        <= 1'b0;
            rsp_slot_level_ff <= 8'd0;
            rsp_slot_empty_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_present_level  = rsp_present_ff;
   assign rsp_out_of_service = rsp_oos_ff;
   assign rsp_slot_level     = rsp_slot_level_ff;
   assign rsp_slot_empty     = rsp_slot_empty_ff;

endmodule

// ===== bench/priority_array_command_table_tb.sv =====
// Testbench of the priority array command table: directed table, then random traffic.
`timescale 1ns / 100ps

module priority_array_command_table_tb;
   import pact_pkg::*;

   // Cycles to let pass once the last result is in.
   localparam int SETTLE_CYCLES = 4;
   // Cycles with no handshake at all before the run is called hung.
   localparam int STALL_LIMIT   = 500;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 175;
   // Index outside the register map; writes to it must be ignored.
   localparam logic [7:0] CSR_UNUSED_INDEX = 8'd2;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  object_number;
      logic [7:0]  priority_req;
      logic [15:0] level_value;
      logic        oos_value;
      logic [7:0]  slot_index;
   } command_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  present_level;
      logic        out_of_service;
      logic [7:0]  slot_level;
      logic        slot_empty;
   } outcome_type;

   // typed = 1: outcome is written out below and checked as is.
   typedef struct packed {
      command_type access;
      logic        typed;
      outcome_type outcome;
   } table_row_type;

   localparam outcome_type NO_OUTCOME      = '{ST_OK, 8'd0, 1'b0, 8'd0, 1'b0};
   localparam outcome_type UNKNOWN_OUTCOME = '{ST_UNKNOWN_OBJECT, 8'd0, 1'b0, 8'd0, 1'b0};

   // Directed part, run right after reset: relinquish default 0, highest level 254,
   // all slots empty, out-of-service clear. Rows run in order, state carries over.
   localparam int DIRECTED_COUNT = 25;
   localparam table_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // reads of a fresh object: slot count, empty slot, index past the last slot
      '{'{CMD_READ, 8'd0, 8'd0, 16'd0, 1'b0, 8'd0}, 1'b1,
        '{ST_OK, 8'd0, 1'b0, PRIORITY_COUNT, 1'b0}},
      '{'{CMD_READ, 8'd0, 8'd0, 16'd0, 1'b0, 8'd1}, 1'b1,
        '{ST_OK, 8'd0, 1'b0, 8'd0, 1'b1}},
      '{'{CMD_READ, 8'd0, 8'd0, 16'd0, 1'b0, 8'd17}, 1'b1,
        '{ST_BAD_INDEX, 8'd0, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_READ, 8'd2, 8'd0, 16'd0, 1'b0, 8'd255}, 1'b1,
        '{ST_BAD_INDEX, 8'd0, 1'b0, 8'd0, 1'b0}},
      // unknown objects: first number past the table and the largest one
      '{'{CMD_WRITE, 8'd4, 8'd1, 16'd5, 1'b0, 8'd0}, 1'b1, UNKNOWN_OUTCOME},
      '{'{CMD_READ, 8'd255, 8'd0, 16'd0, 1'b0, 8'd0}, 1'b1, UNKNOWN_OUTCOME},
      // reserved priority is denied, even with a level that is out of range
      '{'{CMD_WRITE, 8'd0, 8'd6, 16'd10, 1'b0, 8'd0}, 1'b1,
        '{ST_DENIED, 8'd0, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_WRITE, 8'd0, 8'd6, 16'hFFFF, 1'b0, 8'd0}, 1'b1,
        '{ST_DENIED, 8'd0, 1'b0, 8'd0, 1'b0}},
      // bad priorities and levels
      '{'{CMD_WRITE, 8'd0, 8'd0, 16'd5, 1'b0, 8'd0}, 1'b1,
        '{ST_OUT_OF_RANGE, 8'd0, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_WRITE, 8'd0, 8'd17, 16'd5, 1'b0, 8'd0}, 1'b1,
        '{ST_OUT_OF_RANGE, 8'd0, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_WRITE, 8'd0, 8'd255, 16'd5, 1'b0, 8'd0}, 1'b1,
        '{ST_OUT_OF_RANGE, 8'd0, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_WRITE, 8'd0, 8'd16, 16'd255, 1'b0, 8'd0}, 1'b1,
        '{ST_OUT_OF_RANGE, 8'd0, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_WRITE, 8'd0, 8'd16, 16'hFFFF, 1'b0, 8'd0}, 1'b1,
        '{ST_OUT_OF_RANGE, 8'd0, 1'b0, 8'd0, 1'b0}},
      // largest level at the lowest priority, then 0 at the top one overrides it
      '{'{CMD_WRITE, 8'd0, 8'd16, 16'd254, 1'b0, 8'd0}, 1'b1,
        '{ST_OK, 8'd254, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_WRITE, 8'd0, 8'd1, 16'd0, 1'b0, 8'd0}, 1'b1,
        '{ST_OK, 8'd0, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_READ, 8'd0, 8'd0, 16'd0, 1'b0, 8'd16}, 1'b1,
        '{ST_OK, 8'd0, 1'b0, 8'd254, 1'b0}},
      // relinquish: top slot, reserved slot (allowed), bad priorities
      '{'{CMD_RELINQUISH, 8'd0, 8'd1, 16'd0, 1'b0, 8'd0}, 1'b1,
        '{ST_OK, 8'd254, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_RELINQUISH, 8'd0, 8'd6, 16'd0, 1'b0, 8'd0}, 1'b1,
        '{ST_OK, 8'd254, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_RELINQUISH, 8'd0, 8'd0, 16'd0, 1'b0, 8'd0}, 1'b1,
        '{ST_OUT_OF_RANGE, 8'd254, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_RELINQUISH, 8'd0, 8'd17, 16'd0, 1'b0, 8'd0}, 1'b1,
        '{ST_OUT_OF_RANGE, 8'd254, 1'b0, 8'd0, 1'b0}},
      // out-of-service on the last object; a read with every field but the slot index at its max
      '{'{CMD_SET_OOS, 8'd3, 8'd0, 16'd0, 1'b1, 8'd0}, 1'b1,
        '{ST_OK, 8'd0, 1'b1, 8'd0, 1'b0}},
      '{'{CMD_READ, 8'd3, 8'd255, 16'hFFFF, 1'b1, 8'd0}, 1'b1,
        '{ST_OK, 8'd0, 1'b1, PRIORITY_COUNT, 1'b0}},
      '{'{CMD_SET_OOS, 8'd3, 8'd0, 16'd0, 1'b0, 8'd0}, 1'b1,
        '{ST_OK, 8'd0, 1'b0, 8'd0, 1'b0}},
      '{'{CMD_WRITE, 8'd1, 8'd5, 16'd200, 1'b1, 8'd3}, 1'b0, NO_OUTCOME},
      '{'{CMD_RELINQUISH, 8'd200, 8'd1, 16'd0, 1'b0, 8'd0}, 1'b1, UNKNOWN_OUTCOME}
   };

   // Ports; every input is known from time zero.
   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        start              = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd            = '0;
   logic [7:0]  req_object_number  = '0;
   logic [7:0]  req_priority_req   = '0;
   logic [15:0] req_level_value    = '0;
   logic        req_oos_value      = 1'b0;
   logic [7:0]  req_slot_index     = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_present_level;
   logic        rsp_out_of_service;
   logic [7:0]  rsp_slot_level;
   logic        rsp_slot_empty;
   logic        csr_valid          = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index          = '0;
   logic [7:0]  csr_wdata          = '0;

   // Shadow of the block's command tables and registers.
   logic [7:0]  level_slots [OBJECTS][PRIORITIES];
   logic        oos_flags [OBJECTS];
   logic [7:0]  cfg_relinquish_default = RESET_RELINQUISH_DEFAULT;
   logic [7:0]  cfg_highest_level      = RESET_HIGHEST_LEVEL;

   outcome_type pending_outcomes [$];
   int unsigned mismatches   = 0;
   int unsigned quiet_cycles = 0;

   priority_array_command_table u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_object_number  (req_object_number),
      .req_priority_req   (req_priority_req),
      .req_level_value    (req_level_value),
      .req_oos_value      (req_oos_value),
      .req_slot_index     (req_slot_index),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_present_level  (rsp_present_level),
      .rsp_out_of_service (rsp_out_of_service),
      .rsp_slot_level     (rsp_slot_level),
      .rsp_slot_empty     (rsp_slot_empty),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one command to the shadow tables and returns the result it gives.
   function automatic outcome_type apply_command(command_type c);
      outcome_type o;
      int unsigned obj;
      int unsigned pri;
      int unsigned idx;
      bit          pri_ok;
      o      = NO_OUTCOME;
      obj    = c.object_number;
      pri    = c.priority_req;
      idx    = c.slot_index;
      pri_ok = (pri >= 1) && (pri <= PRIORITIES);
      // unknown object: nothing touched, all other fields zero
      if (obj >= OBJECTS) begin
         o.status = ST_UNKNOWN_OBJECT;
         return o;
      end
      case (c.cmd)
         CMD_WRITE: begin
            if (pri_ok && c.priority_req != RESERVED_PRIORITY &&
                c.level_value <= {8'd0, cfg_highest_level} &&
                c.level_value <= {8'd0, MAX_STORABLE}) begin
               level_slots[obj][pri-1] = c.level_value[7:0];
            end else if (c.priority_req == RESERVED_PRIORITY) begin
               // reserved slot is denied before any range check
               o.status = ST_DENIED;
            end else begin
               o.status = ST_OUT_OF_RANGE;
            end
         end
         CMD_RELINQUISH: begin
            if (pri_ok) begin
               level_slots[obj][pri-1] = EMPTY_MARK;
            end else begin
               o.status = ST_OUT_OF_RANGE;
            end
         end
         CMD_SET_OOS: begin
            oos_flags[obj] = c.oos_value;
         end
         default: begin
            if (idx == 0) begin
               o.slot_level = PRIORITY_COUNT;
            end else if (idx <= PRIORITIES) begin
               if (level_slots[obj][idx-1] == EMPTY_MARK) begin
                  o.slot_empty = 1'b1;
               end else begin
                  o.slot_level = level_slots[obj][idx-1];
               end
            end else begin
               o.status = ST_BAD_INDEX;
            end
         end
      endcase
      // scan from the lowest priority up, so the set slot nearest priority 1 wins
      o.present_level = cfg_relinquish_default;
      for (int p = PRIORITIES - 1; p >= 0; p--) begin
         if (level_slots[obj][p] != EMPTY_MARK) begin
            o.present_level = level_slots[obj][p];
         end
      end
      o.out_of_service = oos_flags[obj];
      return o;
   endfunction

   // Mostly valid objects, priorities and indexes; the rest spans the full fields (objects: only past the table).
   function automatic command_type random_command();
      command_type c;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         c.cmd = CMD_WRITE;
      end else if (pick < 6) begin
         c.cmd = CMD_RELINQUISH;
      end else if (pick == 6) begin
         c.cmd = CMD_SET_OOS;
      end else begin
         c.cmd = CMD_READ;
      end
      c.object_number = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(OBJECTS, 255))
                                                      : 8'($urandom_range(0, OBJECTS - 1));
      c.priority_req  = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(1, PRIORITIES));
      case ($urandom_range(0, 6))
         0:       c.level_value = 16'($urandom());
         // straddle the configured ceiling
         1:       c.level_value = 16'(cfg_highest_level) + 16'($urandom_range(0, 3)) - 16'd1;
         default: c.level_value = 16'($urandom_range(0, 254));
      endcase
      c.oos_value  = 1'($urandom_range(0, 1));
      c.slot_index = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, PRIORITIES));
      return c;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Presents one item and holds it until accepted; start stays high on return.
   task automatic issue(command_type c, logic typed, outcome_type typed_outcome);
      outcome_type predicted;
      start             <= 1'b1;
      req_cmd           <= c.cmd;
      req_object_number <= c.object_number;
      req_priority_req  <= c.priority_req;
      req_level_value   <= c.level_value;
      req_oos_value     <= c.oos_value;
      req_slot_index    <= c.slot_index;
      do @(posedge clock); while (busy);
      predicted = apply_command(c);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
   endtask

   task automatic pause(int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stop sending and wait for every outstanding result, then a little longer.
   task automatic drain();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_register(logic [7:0] index, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_RELINQUISH_DEFAULT: cfg_relinquish_default = value;
         CSR_HIGHEST_LEVEL:      cfg_highest_level      = value;
         default: ;
      endcase
   endtask

   task automatic configure(logic [7:0] relinquish_default, logic [7:0] highest_level,
                            bit poke_unused);
      write_register(CSR_HIGHEST_LEVEL, highest_level);
      write_register(CSR_RELINQUISH_DEFAULT, relinquish_default);
      if (poke_unused) begin
         write_register(CSR_UNUSED_INDEX, 8'($urandom()));
      end
      csr_valid <= 1'b0;
   endtask

   // Bursts of back-to-back items with gaps of random length between them;
   // about a quarter of the bursts run straight into the next one.
   task automatic random_phase(int unsigned count);
      int unsigned sent;
      int unsigned burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            if (sent < count) begin
               issue(random_command(), 1'b0, NO_OUTCOME);
               sent++;
            end
         end
         if ($urandom_range(0, 3) != 0) begin
            pause($urandom_range(1, 7));
         end
      end
   endtask

   // Result checker: rsp_valid lasts one cycle and cannot be held off, so each
   // strobe is taken at the edge that ends it and matched to the oldest item.
   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status != want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_present_level != want.present_level)
               report_mismatch("present_level", rsp_present_level, want.present_level);
            if (rsp_out_of_service != want.out_of_service)
               report_mismatch("out_of_service", rsp_out_of_service, want.out_of_service);
            if (rsp_slot_level != want.slot_level)
               report_mismatch("slot_level", rsp_slot_level, want.slot_level);
            if (rsp_slot_empty != want.slot_empty)
               report_mismatch("slot_empty", rsp_slot_empty, want.slot_empty);
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL priority_array_command_table");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [7:0] relinquish_default;
      logic [7:0] highest_level;
      for (int o = 0; o < OBJECTS; o++) begin
         oos_flags[o] = 1'b0;
         for (int p = 0; p < PRIORITIES; p++) begin
            level_slots[o][p] = EMPTY_MARK;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, with a gap after every fourth row
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         issue(DIRECTED_ROWS[r].access, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].outcome);
         if (r % 4 == 3) begin
            pause(1);
         end
      end

      // random phases, one register setting each; extremes first
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: begin relinquish_default = 8'd255; highest_level = 8'd254; end
            1: begin relinquish_default = 8'd0;   highest_level = 8'd0;   end
            2: begin relinquish_default = 8'd100; highest_level = 8'd255; end
            4: begin relinquish_default = 8'd254; highest_level = 8'd128; end
            default: begin
               relinquish_default = 8'($urandom());
               highest_level      = 8'($urandom());
            end
         endcase
         configure(relinquish_default, highest_level, ph == 3);
         random_phase(PHASE_ITEMS);
      end

      drain();
      if (mismatches == 0) begin
         $display("PASS priority_array_command_table");
      end else begin
         $display("FAIL priority_array_command_table");
      end
      $finish;
   end

endmodule
